/* rtl/rau_pkg.sv */
// Package for the rational arithmetic unit: payload structs, command and
// status codes, and the result width. No dependencies.
package rau_pkg;

    localparam int unsigned WIDTH = 32;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_OVERFLOW = 2'd2,
        STAT_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
    } out_t;

endpackage

/* rtl/rational_arithmetic_unit_core.sv */
// Rational arithmetic unit: add, subtract, multiply, divide of fractions
// with reduction by the GCD. Depends on rau_pkg.
//
// One transaction at a time. Cross products are formed on one shared 33x33
// signed multiplier (one product a cycle), then a shared 64-bit restoring
// divider runs Euclid's method (at most about 90 steps) and the two final
// divisions. The result is held in an output register while the next
// transaction may be accepted; a finished result waits until that register
// has been taken.
module rational_arithmetic_unit_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rau_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rau_pkg::out_t m_data
);
    import rau_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_SIGN = 8'b0000_0100,
        ST_GCD  = 8'b0000_1000,
        ST_DIVN = 8'b0001_0000,
        ST_DIVD = 8'b0010_0000,
        ST_CHK  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    in_t    op_reg;
    logic [2:0] step_reg;                     // multiplier step
    logic signed [63:0] p_reg;                // product register
    logic signed [63:0] num_reg, den_reg;
    logic [63:0] mn_reg, md_reg;              // magnitudes
    logic        neg_reg;
    logic [63:0] x_reg, y_reg;                // Euclid pair
    // shared divider
    logic [63:0] dq_reg, dr_reg, dd_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg;
    logic        dstart;
    logic [63:0] dstart_n, dstart_d;
    logic        m_valid_reg;
    logic        out_load;
    out_t        out_reg;

    // multiplier operand selection
    logic signed [32:0] ma, mb;
    logic signed [65:0] mprod;
    always_comb begin
        ma = 33'sd0;
        mb = 33'sd0;
        unique case (step_reg)
            3'd0: begin ma = 33'(op_reg.a_num); mb = $signed({2'b00, op_reg.b_den}); end
            3'd1: begin ma = 33'(op_reg.b_num); mb = $signed({2'b00, op_reg.a_den}); end
            3'd2: begin ma = 33'(op_reg.a_num); mb = 33'(op_reg.b_num); end
            3'd3: begin
                ma = $signed({2'b00, op_reg.a_den});
                mb = $signed({2'b00, op_reg.b_den});
            end
            3'd4: begin ma = $signed({2'b00, op_reg.a_den}); mb = 33'(op_reg.b_num); end
            default: begin ma = 33'sd0; mb = 33'sd0; end
        endcase
        mprod = ma * mb;
    end

    // one restoring division step
    logic [64:0] trial;
    logic [63:0] rsh;
    always_comb begin
        rsh   = {dr_reg[62:0], dq_reg[63]};
        trial = {dr_reg, dq_reg[63]} - {1'b0, dd_reg};
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    logic [63:0] lim;
    assign lim = 64'd1 << (WIDTH - 1);

    always_comb begin
        state_next = state_reg;
        dstart = 1'b0;
        dstart_n = x_reg;
        dstart_d = y_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid && s_ready) state_next = ST_MUL;
            ST_MUL:  if (step_reg == 3'd5) state_next = ST_SIGN;
            ST_SIGN: state_next = ST_GCD;
            ST_GCD: begin
                // a fresh remainder is taken first, the next step starts after
                if (!dbusy_reg && dcnt_reg != 7'd64) begin
                    if (y_reg == 64'd0) begin
                        state_next = ST_DIVN;
                        dstart = (x_reg != 64'd0);
                        dstart_n = mn_reg;
                        dstart_d = x_reg;
                    end else begin
                        dstart = 1'b1;
                    end
                end
            end
            ST_DIVN: if (!dbusy_reg) begin
                state_next = ST_DIVD;
                dstart = (x_reg != 64'd0);
                dstart_n = md_reg;
                dstart_d = x_reg;
            end
            ST_DIVD: if (!dbusy_reg) state_next = ST_CHK;
            ST_CHK:  state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            dbusy_reg   <= 1'b0;
            step_reg    <= 3'd0;
        end else begin
            state_reg <= state_next;
            // hold output until taken, load a new result once it is free
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    op_reg   <= s_data;
                    step_reg <= 3'd0;
                end
                ST_MUL: begin
                    // accumulate cross products, one per cycle
                    if (step_reg != 3'd0) begin
                        unique case (step_reg)
                            3'd1: num_reg <= p_reg;
                            3'd2: begin
                                if (op_reg.cmd == CMD_ADD) num_reg <= num_reg + p_reg;
                                else if (op_reg.cmd == CMD_SUB) num_reg <= num_reg - p_reg;
                            end
                            3'd3: if (op_reg.cmd == CMD_MUL) num_reg <= p_reg;
                            3'd4: den_reg <= p_reg;
                            3'd5: if (op_reg.cmd == CMD_DIV) den_reg <= p_reg;
                            default: ;
                        endcase
                    end
                    p_reg    <= 64'(mprod);
                    step_reg <= step_reg + 3'd1;
                end
                ST_SIGN: begin
                    neg_reg <= num_reg[63] != den_reg[63];
                    mn_reg  <= num_reg[63] ? 64'd0 - num_reg : num_reg;
                    md_reg  <= den_reg[63] ? 64'd0 - den_reg : den_reg;
                    x_reg   <= num_reg[63] ? 64'd0 - num_reg : num_reg;
                    y_reg   <= den_reg[63] ? 64'd0 - den_reg : den_reg;
                end
                ST_GCD: if (!dbusy_reg && y_reg != 64'd0 && dcnt_reg == 7'd64) begin
                    // advance Euclid with the fresh remainder
                    x_reg <= y_reg;
                    y_reg <= dr_reg;
                end
                ST_DIVN: if (!dbusy_reg && x_reg != 64'd0) mn_reg <= dq_reg;
                ST_DIVD: if (!dbusy_reg && x_reg != 64'd0) md_reg <= dq_reg;
                ST_CHK: begin
                    if (mn_reg == 64'd0) begin
                        md_reg  <= 64'd1;
                        neg_reg <= 1'b0;
                    end
                end
                ST_OUT: if (out_load) begin
                    out_reg.res_num <= 32'sd0;
                    out_reg.res_den <= 31'd0;
                    if (op_reg.a_den == 31'd0 || op_reg.b_den == 31'd0
                        || den_reg == 64'sd0) begin
                        out_reg.status <= STAT_ZERO_DEN;
                    end else if (md_reg > lim - 64'd1
                        || (neg_reg ? mn_reg > lim : mn_reg > lim - 64'd1)) begin
                        out_reg.status <= STAT_OVERFLOW;
                    end else begin
                        out_reg.status  <= STAT_OK;
                        out_reg.res_num <= neg_reg ? 32'(64'd0 - mn_reg) : mn_reg[31:0];
                        out_reg.res_den <= md_reg[30:0];
                    end
                end
                default: ;
            endcase

            // shared divider: one quotient bit per cycle
            if (dstart) begin
                dbusy_reg <= 1'b1;
                dq_reg    <= dstart_n;
                dr_reg    <= 64'd0;
                dd_reg    <= dstart_d;
                dcnt_reg  <= 7'd0;
            end else if (dbusy_reg) begin
                if (!trial[64]) begin
                    dr_reg <= trial[63:0];
                    dq_reg <= {dq_reg[62:0], 1'b1};
                end else begin
                    dr_reg <= rsh;
                    dq_reg <= {dq_reg[62:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 7'd1;
                if (dcnt_reg == 7'd63) dbusy_reg <= 1'b0;
            end else if (state_reg == ST_GCD && y_reg != 64'd0 && dcnt_reg == 7'd64) begin
                dcnt_reg <= 7'd0;
            end else if (state_reg == ST_SIGN) begin
                dcnt_reg <= 7'd0;
            end
        end
    end

endmodule

/* tb/rau_checker.sv */
// Checker for the rational arithmetic unit: watches both channels, predicts
// each result from the accepted operands and compares it. Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  rau_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  rau_pkg::out_t m_data,
    output int            fail_count,
    output int            results_pending
);
    import rau_pkg::*;

    out_t expected_results[$];

    // Combine two fractions, reduce by the GCD and range-check at WIDTH
    function automatic out_t reduce_fraction(in_t t);
        longint an, ad, bn, bd, num, den;
        longint unsigned mn, md, x, y, r, lim;
        bit neg;
        out_t o;
        an = t.a_num;
        bn = t.b_num;
        ad = longint'({33'd0, t.a_den});
        bd = longint'({33'd0, t.b_den});
        case (cmd_t'(t.cmd))
            CMD_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            CMD_SUB: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            CMD_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        o = '0;
        if (ad == 0 || bd == 0 || den == 0) begin
            o.status = STAT_ZERO_DEN;
            return o;
        end
        neg = (num < 0) != (den < 0);
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        // Euclid on the magnitudes
        x = mn;
        y = md;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        if (x != 0) begin
            mn = mn / x;
            md = md / x;
        end
        if (mn == 0) begin
            md = 1;
            neg = 1'b0;
        end
        lim = 64'd1 << (WIDTH - 1);
        if (md > lim - 1 || (neg ? mn > lim : mn > lim - 1)) begin
            o.status = STAT_OVERFLOW;
        end else begin
            o.res_num = 32'(neg ? -mn : mn);
            o.res_den = 31'(md);
            o.status = STAT_OK;
        end
        return o;
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge aclk) begin
        out_t exp_r;
        int   errs;
        errs = 0;
        if (!aresetn) begin
            expected_results.delete();
            fail_count <= 0;
            results_pending <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(reduce_fraction(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction num=%0d den=%0d status=%0d",
                           m_data.res_num, m_data.res_den, m_data.status);
                    errs++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data.res_num !== exp_r.res_num) begin
                        $error("res_num expected %0d actual %0d",
                               exp_r.res_num, m_data.res_num);
                        errs++;
                    end
                    if (m_data.res_den !== exp_r.res_den) begin
                        $error("res_den expected %0d actual %0d",
                               exp_r.res_den, m_data.res_den);
                        errs++;
                    end
                    if (m_data.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d",
                               exp_r.status, m_data.status);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            results_pending <= expected_results.size();
        end
    end
endmodule

/* tb/tb_rational_arithmetic_unit_core.sv */
// Testbench top for the rational arithmetic unit: clock, reset, operand
// stimulus, result back-pressure and the verdict. Depends on rau_pkg and
// rau_checker.
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit_core;
    import rau_pkg::*;

    localparam int RANDOM_ITEMS = 780;
    localparam int LONG_HOLD_AT = 40;
    localparam int LONG_HOLD_CYCLES = 3000;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;
    int    fail_count;
    int    results_pending;
    bit    stimulus_done;
    in_t   directed_ops[$];

    rational_arithmetic_unit_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    rau_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic in_t make_op(cmd_t c, logic [31:0] an, logic [30:0] ad,
                                    logic [31:0] bn, logic [30:0] bd);
        in_t t;
        t.cmd = c;
        t.a_num = an;
        t.a_den = ad;
        t.b_num = bn;
        t.b_den = bd;
        return t;
    endfunction

    // Random magnitude of varied size, so small and large values both occur
    function automatic logic [31:0] rand_word();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic in_t random_op();
        in_t t;
        t.cmd = cmd_t'($urandom_range(0, 3));
        t.a_num = ($urandom_range(0, 1)) ? rand_word() : -rand_word();
        t.b_num = ($urandom_range(0, 1)) ? rand_word() : -rand_word();
        if ($urandom_range(0, 15) == 0) t.b_num = '0;
        if ($urandom_range(0, 15) == 0) t.a_num = $urandom;
        t.a_den = 31'(rand_word() >> 1);
        t.b_den = 31'(rand_word() >> 1);
        if (t.a_den == 31'd0) t.a_den = 31'd1;
        if (t.b_den == 31'd0) t.b_den = 31'd1;
        // occasional zero denominator
        if ($urandom_range(0, 24) == 0) t.a_den = 31'd0;
        if ($urandom_range(0, 24) == 0) t.b_den = 31'd0;
        return t;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted;
    // valid stays high on return, the next call or the caller drops it
    task automatic send_op(in_t t);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        @(negedge aclk);
    endtask

    // Result side: random stall per transaction, none for transactions 201 to 259, one long hold-off
    initial begin
        int stall;
        int taken;
        m_ready = 1'b0;
        taken = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = (taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : $urandom_range(0, 5);
            if (taken > 200 && taken < 260) stall = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_valid) break;
            end
            taken++;
            @(negedge aclk);
        end
    end

    // Stimulus
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        stimulus_done = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_ops.push_back(make_op(CMD_ADD, 1, 2, 1, 3));
        directed_ops.push_back(make_op(CMD_SUB, 1, 2, 1, 2));
        directed_ops.push_back(make_op(CMD_MUL, -3, 4, 4, 3));
        directed_ops.push_back(make_op(CMD_DIV, 5, 7, -10, 21));
        directed_ops.push_back(make_op(CMD_DIV, 5, 7, 0, 1));
        directed_ops.push_back(make_op(CMD_ADD, 1, 0, 1, 1));
        directed_ops.push_back(make_op(CMD_MUL, 1, 1, 1, 0));
        directed_ops.push_back(make_op(CMD_DIV, 0, 0, 0, 0));
        directed_ops.push_back(make_op(CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
        directed_ops.push_back(make_op(CMD_MUL, 32'h8000_0000, 1, 1, 1));
        directed_ops.push_back(make_op(CMD_MUL, 32'h8000_0000, 1, -1, 1));
        directed_ops.push_back(make_op(CMD_ADD, 32'h7FFF_FFFF, 1, 1, 1));
        directed_ops.push_back(make_op(CMD_SUB, 32'h8000_0000, 1, 1, 1));
        directed_ops.push_back(make_op(CMD_SUB, 32'h8000_0000, 1, 0, 1));
        directed_ops.push_back(make_op(CMD_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                       32'h8000_0000, 31'h7FFF_FFFF));
        directed_ops.push_back(make_op(CMD_MUL, 1, 31'h7FFF_FFFF, 1, 31'h7FFF_FFFF));
        directed_ops.push_back(make_op(CMD_DIV, 1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        directed_ops.push_back(make_op(CMD_DIV, 32'h8000_0000, 1, -1, 1));
        directed_ops.push_back(make_op(CMD_ADD, 6, 4, 9, 6));
        directed_ops.push_back(make_op(CMD_SUB, 0, 5, 0, 9));
        directed_ops.push_back(make_op(CMD_MUL, 0, 31'h7FFF_FFFF, -7, 3));
        directed_ops.push_back(make_op(CMD_DIV, -8, 3, -4, 9));
        directed_ops.push_back(make_op(CMD_DIV, 32'hFFFF_FFFF, 31'h4000_0000,
                                       32'h5555_5555, 31'h2AAA_AAAA));
        foreach (directed_ops[i]) send_op(directed_ops[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // drain once midway so the block goes fully idle
            if (n == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                wait (results_pending == 0 && !m_valid);
                @(negedge aclk);
            end
            send_op(random_op());
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Verdict
    initial begin
        wait (stimulus_done);
        @(negedge aclk);
        wait (results_pending == 0);
        repeat (7000) @(posedge aclk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
